### rtl/core/sbmd_pkg.sv
// ----------------------------------------------------------------------------
// sbmd_pkg: shared types and constants of the basic-mode serial deframer
// Event codes, the event record passed from front to back, framing constants.
// ----------------------------------------------------------------------------
`default_nettype none

package sbmd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned POS_W  = 16;
  localparam int unsigned STAT_W = 32;
  localparam int unsigned CFG_INDEX_W = 2;

  localparam logic [BYTE_W-1:0] ESC_FLIP      = 8'h10;
  localparam logic [POS_W-1:0]  POS_MAX       = 16'hFFFF;
  localparam logic [POS_W-1:0]  MIN_FRAME_LEN = 16'd7;
  localparam logic [POS_W-1:0]  HEADER_LEN    = 16'd3;

  localparam logic [BYTE_W-1:0] START_CODE_RST  = 8'hA0;
  localparam logic [BYTE_W-1:0] STOP_CODE_RST   = 8'hA5;
  localparam logic [BYTE_W-1:0] ESCAPE_CODE_RST = 8'hAA;

  // Event queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    EV_DATA  = 2'd0,
    EV_GOOD  = 2'd1,
    EV_BAD   = 2'd2,
    EV_ABORT = 2'd3
  } ev_kind_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_START  = 2'd0,
    REG_STOP   = 2'd1,
    REG_ESCAPE = 2'd2
  } reg_index_t;

  typedef struct packed {
    ev_kind_t          kind;
    logic [BYTE_W-1:0] data;
    logic [POS_W-1:0]  pos;
  } ev_t;

endpackage

`default_nettype wire

### rtl/core/sbmd_front.sv
// ----------------------------------------------------------------------------
// sbmd_front: byte classifier and frame parser
// Strips start, stop and escape framing and emits one event per byte at most.
// ----------------------------------------------------------------------------
`default_nettype none

module sbmd_front import sbmd_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_wr,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0]      cfg_data,
  input  wire logic                   in_take,
  input  wire logic [BYTE_W-1:0]      rx_byte,
  output logic                        ev_valid,
  output ev_t                         ev
);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_FRAME = 2'd1,
    PH_ESC   = 2'd2,
    PH_DONE  = 2'd3
  } phase_t;

  phase_t             phase, phase_next;
  logic [POS_W-1:0]   frame_length, frame_length_next;
  logic [BYTE_W-1:0]  header_sum, header_sum_next;
  logic [BYTE_W-1:0]  body_sum, body_sum_next;
  logic [BYTE_W-1:0]  start_code, stop_code, escape_code;
  logic [BYTE_W-1:0]  data_val;
  logic               take_data;
  logic               good;

  assign good = (frame_length >= MIN_FRAME_LEN) && (header_sum == '0) && (body_sum == '0);

  always_comb begin
    phase_next        = phase;
    frame_length_next = frame_length;
    header_sum_next   = header_sum;
    body_sum_next     = body_sum;
    take_data         = 1'b0;
    data_val          = rx_byte;
    ev_valid          = 1'b0;
    ev                = '{kind: EV_DATA, data: '0, pos: frame_length};
    if (in_take) begin
      case (phase)
        PH_FRAME: begin
          if (rx_byte == escape_code) begin
            phase_next = PH_ESC;
          end else if (rx_byte == stop_code) begin
            ev_valid          = 1'b1;
            ev.kind           = good ? EV_GOOD : EV_BAD;
            phase_next        = PH_DONE;
            frame_length_next = '0;
            header_sum_next   = '0;
            body_sum_next     = '0;
          end else if (rx_byte == start_code) begin
            // restart: report the discarded length, open a fresh frame
            ev_valid          = 1'b1;
            ev.kind           = EV_ABORT;
            frame_length_next = '0;
            header_sum_next   = '0;
            body_sum_next     = '0;
          end else begin
            take_data = 1'b1;
          end
        end
        PH_ESC: begin
          phase_next = PH_FRAME;
          data_val   = rx_byte ^ ESC_FLIP;
          take_data  = 1'b1;
        end
        default: begin
          if (rx_byte == start_code) begin
            phase_next        = PH_FRAME;
            frame_length_next = '0;
            header_sum_next   = '0;
            body_sum_next     = '0;
          end else begin
            phase_next = PH_IDLE;
          end
        end
      endcase
      if (take_data) begin
        ev_valid = 1'b1;
        ev.kind  = EV_DATA;
        ev.data  = data_val;
        if (frame_length < HEADER_LEN) begin
          header_sum_next = header_sum + data_val;
        end else begin
          body_sum_next = body_sum + data_val;
        end
        if (frame_length != POS_MAX) begin
          frame_length_next = frame_length + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      frame_length <= '0;
      header_sum   <= '0;
      body_sum     <= '0;
      start_code   <= START_CODE_RST;
      stop_code    <= STOP_CODE_RST;
      escape_code  <= ESCAPE_CODE_RST;
    end else begin
      phase        <= phase_next;
      frame_length <= frame_length_next;
      header_sum   <= header_sum_next;
      body_sum     <= body_sum_next;
      if (cfg_wr) begin
        case (cfg_index)
          REG_START:  start_code  <= cfg_data;
          REG_STOP:   stop_code   <= cfg_data;
          REG_ESCAPE: escape_code <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // an escaped byte always becomes a data event
  a_esc_is_data: assert property (@(posedge clk) disable iff (rst)
    (in_take && phase == PH_ESC) |-> (ev_valid && ev.kind == EV_DATA))
    else $error("escaped byte did not yield a data event");

endmodule

`default_nettype wire

### rtl/core/sbmd_queue.sv
// ----------------------------------------------------------------------------
// sbmd_queue: short event queue between parser and statistics stage
// Two entries, so the parser and the result side stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module sbmd_queue import sbmd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_valid,
  input  wire ev_t  wr_ev,
  output logic      full,
  input  wire logic rd_ready,
  output logic      rd_valid,
  output ev_t       rd_ev
);

  ev_t               slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              rd_en;

  assign full     = (count == QCNT_W'(QDEPTH));
  assign rd_valid = (count != '0);
  assign rd_en    = rd_ready && rd_valid;
  assign rd_ev    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_valid) begin
      slots[wr_ptr] <= wr_ev;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_valid) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({wr_valid, rd_en})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr_valid |-> !full)
    else $error("event written into a full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("queue fill count out of range");

endmodule

`default_nettype wire

### rtl/core/sbmd_back.sv
// ----------------------------------------------------------------------------
// sbmd_back: statistics counters and result register
// Takes events in order, updates the counters and presents one result.
// ----------------------------------------------------------------------------
`default_nettype none

module sbmd_back import sbmd_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              ev_valid,
  input  wire ev_t               ev,
  output logic                   ev_take,
  output logic                   empty,
  input  wire logic              pop,
  output logic [1:0]             event_kind,
  output logic [BYTE_W-1:0]      data_byte,
  output logic [POS_W-1:0]       byte_position,
  output logic [STAT_W-1:0]      frames_received,
  output logic [STAT_W-1:0]      frames_valid,
  output logic [STAT_W-1:0]      checksum_errors,
  output logic [STAT_W-1:0]      bytes_received
);

  logic                   out_valid;
  logic [COUNT_WIDTH-1:0] received_count, received_count_next;
  logic [COUNT_WIDTH-1:0] valid_count, valid_count_next;
  logic [COUNT_WIDTH-1:0] error_count, error_count_next;
  logic [COUNT_WIDTH-1:0] byte_total, byte_total_next;

  assign empty   = !out_valid;
  assign ev_take = ev_valid && (!out_valid || pop);

  always_comb begin
    received_count_next = received_count;
    valid_count_next    = valid_count;
    error_count_next    = error_count;
    byte_total_next     = byte_total;
    case (ev.kind)
      EV_GOOD: begin
        received_count_next = received_count + COUNT_WIDTH'(1);
        valid_count_next    = valid_count + COUNT_WIDTH'(1);
        byte_total_next     = byte_total + COUNT_WIDTH'(ev.pos);
      end
      EV_BAD: begin
        received_count_next = received_count + COUNT_WIDTH'(1);
        error_count_next    = error_count + COUNT_WIDTH'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      received_count <= '0;
      valid_count    <= '0;
      error_count    <= '0;
      byte_total     <= '0;
    end else begin
      if (ev_take) begin
        out_valid      <= 1'b1;
        received_count <= received_count_next;
        valid_count    <= valid_count_next;
        error_count    <= error_count_next;
        byte_total     <= byte_total_next;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ev_take) begin
      event_kind      <= ev.kind;
      data_byte       <= ev.data;
      byte_position   <= ev.pos;
      frames_received <= STAT_W'(received_count_next);
      frames_valid    <= STAT_W'(valid_count_next);
      checksum_errors <= STAT_W'(error_count_next);
      bytes_received  <= STAT_W'(byte_total_next);
    end
  end

  a_good_counts: assert property (@(posedge clk) disable iff (rst)
    (ev_take && ev.kind == EV_GOOD) |=>
      (received_count == $past(received_count) + COUNT_WIDTH'(1)))
    else $error("good frame did not advance the frame count");

  a_data_keeps_stats: assert property (@(posedge clk) disable iff (rst)
    (ev_take && (ev.kind == EV_DATA || ev.kind == EV_ABORT)) |=>
      ($stable(valid_count) && $stable(error_count) && $stable(received_count)))
    else $error("data or abort event changed the statistics");

  a_end_data_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && event_kind != EV_DATA) |-> (data_byte == '0))
    else $error("frame end result carries a data byte");

endmodule

`default_nettype wire

### rtl/core/serial_basic_mode_deframer_unit.sv
// ----------------------------------------------------------------------------
// serial_basic_mode_deframer_unit: basic-mode serial deframer, top level
// Strips start/stop/escape framing from received bytes, reports every frame
// byte with its position and a good/bad/aborted verdict at each frame end,
// together with four wrapping statistics counters.
// ----------------------------------------------------------------------------
//
//  channel   | handshake           | beat carries
//  ----------+---------------------+-------------------------------------------
//  input     | push / full         | rx_byte
//  result    | pop / empty         | event_kind, data_byte, byte_position,
//            |                     | frames_received, frames_valid,
//            |                     | checksum_errors, bytes_received
//  config    | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  One byte is taken every cycle while full is low; the parser settles each
//  byte in the cycle it is taken. The edge that takes a byte writes any event
//  it yields into the event queue; the result register loads the event from
//  there once it is empty or being popped. Reset (rst, synchronous) returns the
//  codes to 0xA0/0xA5/0xAA, the parser to idle and every counter to zero.
//  full rises only once the two-entry event queue is occupied while the result
//  register waits for pop. cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_basic_mode_deframer_unit import sbmd_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // byte input
  input  wire logic                   push,
  output logic                        full,
  input  wire logic [BYTE_W-1:0]      rx_byte,
  // results
  input  wire logic                   pop,
  output logic                        empty,
  output logic [1:0]                  event_kind,
  output logic [BYTE_W-1:0]           data_byte,
  output logic [POS_W-1:0]            byte_position,
  output logic [STAT_W-1:0]           frames_received,
  output logic [STAT_W-1:0]           frames_valid,
  output logic [STAT_W-1:0]           checksum_errors,
  output logic [STAT_W-1:0]           bytes_received,
  // register writes
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0]      cfg_data
);

  logic in_take;
  logic front_ev_valid;
  ev_t  front_ev;
  logic q_rd_valid;
  ev_t  q_rd_ev;
  logic back_take;

  // Register writes go straight into the code registers, so never hold the channel
  assign cfg_ready = 1'b1;

  // Accept a beat whenever the event queue has room
  assign in_take = push && !full;

  sbmd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_take   (in_take),
    .rx_byte   (rx_byte),
    .ev_valid  (front_ev_valid),
    .ev        (front_ev)
  );

  // Decouple parsing from the result side
  sbmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (front_ev_valid),
    .wr_ev    (front_ev),
    .full     (full),
    .rd_ready (back_take),
    .rd_valid (q_rd_valid),
    .rd_ev    (q_rd_ev)
  );

  // Advance counters in event order and hold the result until popped
  sbmd_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .ev_valid        (q_rd_valid),
    .ev              (q_rd_ev),
    .ev_take         (back_take),
    .empty           (empty),
    .pop             (pop),
    .event_kind      (event_kind),
    .data_byte       (data_byte),
    .byte_position   (byte_position),
    .frames_received (frames_received),
    .frames_valid    (frames_valid),
    .checksum_errors (checksum_errors),
    .bytes_received  (bytes_received)
  );

endmodule

`default_nettype wire
